### rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every clock edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lcg48_pkg.sv
package lcg48_pkg;

  localparam int unsigned StateWidth  = 48;
  localparam int unsigned RedrawLimit = 64;
  localparam int unsigned TryWidth    = $clog2(RedrawLimit + 1);

  localparam logic [StateWidth-1:0] MultReset = 48'd25214903917;
  localparam logic [StateWidth-1:0] IncrReset = 48'd11;

  typedef enum logic [2:0] {
    ActReseed = 3'd0,
    ActBits   = 3'd1,
    ActLong   = 3'd2,
    ActFrac   = 3'd3,
    ActBound  = 3'd4
  } action_e;

  typedef enum logic [0:0] {
    CfgMult = 1'b0,
    CfgIncr = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StStep,
    StStepWait,
    StDraw,
    StDivStart,
    StDivWait,
    StCheck,
    StDone
  } state_e;

  typedef struct packed {
    logic start;
  } unit_ctl_t;

endpackage

### rtl/lcg48_mul_unit.sv
module lcg48_mul_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lcg48_pkg::unit_ctl_t                 ctl_i,
  input  logic [lcg48_pkg::StateWidth-1:0]     state_i,
  input  logic [lcg48_pkg::StateWidth-1:0]     mult_i,
  input  logic [lcg48_pkg::StateWidth-1:0]     incr_i,
  output logic                                 busy_o,
  output logic [lcg48_pkg::StateWidth-1:0]     result_o
);
  import lcg48_pkg::*;

  localparam int unsigned Digit  = 16;
  localparam int unsigned NDig   = StateWidth / Digit;
  localparam int unsigned CntW   = $clog2(NDig + 1);

  logic [StateWidth-1:0] acc_q, acc_d;
  logic [StateWidth-1:0] mcand_q, mcand_d;
  logic [StateWidth-1:0] mplier_q, mplier_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic [StateWidth+Digit-1:0] prod;

  assign prod = mcand_q * mplier_q[Digit-1:0];

  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    if (ctl_i.start) begin
      acc_d    = incr_i;
      mcand_d  = state_i;
      mplier_d = mult_i;
      cnt_d    = CntW'(NDig);
      busy_d   = 1'b1;
    end else if (busy_q) begin
      acc_d    = acc_q + prod[StateWidth-1:0];
      mcand_d  = mcand_q << Digit;
      mplier_d = mplier_q >> Digit;
      cnt_d    = cnt_q - 1'b1;
      busy_d   = (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign busy_o   = busy_q;
  assign result_o = acc_q;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_cnt_idle, clk_i, rst_ni, !busy_q, cnt_q == '0, "mul count not zero when idle")
  `ASSERT_NEXT(a_start_busy, clk_i, rst_ni, ctl_i.start, busy_q, "mul did not start")
  `ASSERT_IMPL(a_no_restart, clk_i, rst_ni, busy_q, !ctl_i.start, "mul restarted while busy")
endmodule

### rtl/lcg48_div_unit.sv
module lcg48_div_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcg48_pkg::unit_ctl_t ctl_i,
  input  logic [31:0]          dividend_i,
  input  logic [31:0]          divisor_i,
  output logic                 busy_o,
  output logic [31:0]          rem_o
);
  import lcg48_pkg::*;

  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem_q, quo_q[31]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (ctl_i.start) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[30:0], 1'b0};
      rem_d  = trial[32] ? shifted[31:0] : trial[31:0];
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_div_rem_lt, clk_i, rst_ni, busy_q && dvs_q != '0, rem_q < dvs_q,
               "partial remainder not below divisor")
  `ASSERT_IMPL(a_div_idle, clk_i, rst_ni, !busy_q, cnt_q == '0, "div count not zero when idle")
endmodule

### rtl/lcg48_random_generator.sv
// 48-bit linear congruential random generator.
// Input channel: in_valid_i / in_stall_o with action_i, seed_value_i, bit_count_i and
// upper_bound_i; a beat is taken when in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o / out_stall_i with value_o; one result beat per input beat.
// Configuration: cfg_we_i writes cfg_data_i into the register at cfg_idx_i
// (0 multiplier, 1 increment); write only while no item is in flight.
// Each state step runs through one shared multiplier that adds one 16-bit digit
// partial product per cycle. A reseed goes straight to the result without a state
// step; a bits draw steps the state once, and 64-bit and fraction draws twice.
// Bounded draws with a non-power-of-two bound add a shift-subtract remainder per
// draw and redraw up to 64 times on rejection.
// The block takes one item at a time: in_stall_o is high from acceptance until the
// result beat has been taken, and drops in the cycle after that.
// A stalled result holds in its output register.
// Reset loads the state with the reset multiplier and the registers with their
// reset values; the block is ready in the first cycle after reset.
module lcg48_random_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [63:0] seed_value_i,
  input  logic [5:0]  bit_count_i,
  input  logic [31:0] upper_bound_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] value_o
);
  import lcg48_pkg::*;

  state_e st_q, st_d;
  logic [StateWidth-1:0] mult_q, incr_q, gen_q, gen_d;
  logic [2:0]  act_q, act_d;
  logic [5:0]  nb_q, nb_d;
  logic [31:0] bound_q, bound_d;
  logic [63:0] val_q, val_d;
  logic [31:0] hi_q, hi_d;
  logic [31:0] u_q, u_d;
  logic        phase_q, phase_d;
  logic [TryWidth-1:0] tries_q, tries_d;
  unit_ctl_t   mul_ctl, div_ctl;
  logic        mul_busy, div_busy;
  logic [StateWidth-1:0] mul_res;
  logic [31:0] div_rem;
  logic [5:0]  nb_sat;
  logic [31:0] top_bits;
  logic [31:0] rej;
  logic        accept;

  assign accept = in_valid_i && (st_q == StIdle);
  assign nb_sat = (bit_count_i > 6'd32) ? 6'd32 : bit_count_i;
  assign top_bits = (nb_q == 6'd0) ? 32'd0
                  : 32'(mul_res >> (StateWidth - 32'(nb_q)));
  assign rej = u_q - div_rem + (bound_q - 32'd1);

  lcg48_mul_unit u_mul (
    .clk_i, .rst_ni, .ctl_i(mul_ctl), .state_i(gen_q), .mult_i(mult_q), .incr_i(incr_q),
    .busy_o(mul_busy), .result_o(mul_res)
  );

  lcg48_div_unit u_div (
    .clk_i, .rst_ni, .ctl_i(div_ctl), .dividend_i(u_q), .divisor_i(bound_q),
    .busy_o(div_busy), .rem_o(div_rem)
  );

  always_comb begin
    st_d = st_q; gen_d = gen_q; act_d = act_q; nb_d = nb_q; bound_d = bound_q;
    val_d = val_q; hi_d = hi_q; u_d = u_q; phase_d = phase_q; tries_d = tries_q;
    mul_ctl = '0; div_ctl = '0;
    unique case (st_q)
      StIdle: begin
        if (accept) begin
          act_d = action_i; nb_d = nb_sat; bound_d = upper_bound_i;
          phase_d = 1'b0; tries_d = '0; val_d = '0;
          st_d = StDone;
          case (action_i)
            ActReseed: gen_d = seed_value_i[StateWidth-1:0] ^ mult_q;
            ActBits: st_d = StStep;
            ActLong: begin nb_d = 6'd32; st_d = StStep; end
            ActFrac: begin nb_d = 6'd26; st_d = StStep; end
            ActBound: begin
              nb_d = 6'd31;
              if (upper_bound_i != '0 && !upper_bound_i[31]) st_d = StStep;
            end
            default: ;
          endcase
        end
      end
      StStep: begin
        mul_ctl.start = 1'b1;
        st_d = StStepWait;
      end
      StStepWait: if (!mul_busy) st_d = StDraw;
      StDraw: begin
        gen_d = mul_res;
        st_d = StDone;
        case (act_q)
          ActBits: val_d = nb_q[5] ? {{32{top_bits[31]}}, top_bits} : {32'd0, top_bits};
          ActLong: begin
            if (!phase_q) begin
              hi_d = top_bits; phase_d = 1'b1; st_d = StStep;
            end else begin
              val_d = {hi_q, 32'd0} + {{32{top_bits[31]}}, top_bits};
            end
          end
          ActFrac: begin
            if (!phase_q) begin
              hi_d = top_bits; phase_d = 1'b1; nb_d = 6'd27; st_d = StStep;
            end else begin
              val_d = ({32'd0, hi_q} << 27) + {32'd0, top_bits};
            end
          end
          default: begin
            u_d = top_bits;
            if ((bound_q & (bound_q - 32'd1)) == '0) begin
              val_d = 64'(({32'd0, bound_q} * {32'd0, top_bits}) >> 31);
            end else begin
              st_d = StDivStart;
            end
          end
        endcase
      end
      StDivStart: begin
        div_ctl.start = 1'b1;
        st_d = StDivWait;
      end
      StDivWait: if (!div_busy) st_d = StCheck;
      StCheck: begin
        val_d = {32'd0, div_rem};
        if (rej[31] && tries_q != TryWidth'(RedrawLimit)) begin
          tries_d = tries_q + 1'b1;
          st_d = StStep;
        end else begin
          st_d = StDone;
        end
      end
      StDone: if (!out_stall_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      mult_q  <= MultReset;
      incr_q  <= IncrReset;
      gen_q   <= MultReset;
      phase_q <= 1'b0;
      tries_q <= '0;
    end else begin
      st_q    <= st_d;
      gen_q   <= gen_d;
      phase_q <= phase_d;
      tries_q <= tries_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgMult) mult_q <= cfg_data_i;
        else incr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    nb_q    <= nb_d;
    bound_q <= bound_d;
    val_q   <= val_d;
    hi_q    <= hi_d;
    u_q     <= u_d;
  end

  assign in_stall_o  = (st_q != StIdle);
  assign out_valid_o = (st_q == StDone);
  assign value_o     = val_q;

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_hold_result, clk_i, rst_ni, out_valid_o && out_stall_i,
               out_valid_o && $stable(value_o), "result dropped while stalled")
  `ASSERT_IMPL(a_tries_bound, clk_i, rst_ni, 1'b1, tries_q <= TryWidth'(RedrawLimit),
               "redraw count overran")
  `ASSERT_IMPL(a_units_excl, clk_i, rst_ni, 1'b1, !(mul_busy && div_busy),
               "multiplier and divider busy together")
endmodule
